### sv/wsfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_pkg
// Beat types, status codes and opcode decode for the frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } ws_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic [2:0]  frame_status;
    logic [63:0] frame_length;
    logic        last_result;
  } ws_out_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ST_TEXT   = 3'd0;
  localparam logic [2:0] ST_BINARY = 3'd1;
  localparam logic [2:0] ST_CLOSE  = 3'd2;
  localparam logic [2:0] ST_PING   = 3'd3;
  localparam logic [2:0] ST_PONG   = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;
  localparam logic [2:0] ST_TRUNC  = 3'd6;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  function automatic logic [2:0] action_of(input logic [3:0] op);
    logic [2:0] st;
    case (op)
      OP_TEXT:   st = ST_TEXT;
      OP_BINARY: st = ST_BINARY;
      OP_CLOSE:  st = ST_CLOSE;
      OP_PING:   st = ST_PING;
      OP_PONG:   st = ST_PONG;
      default:   st = ST_UNKNOWN;
    endcase
    return st;
  endfunction

endpackage

### sv/websocket_frame_parser_core.sv
`timescale 1ns / 1ps
// Results are registered in the result queue when their input beat is accepted.
// Throughput: one input beat per cycle while the output does not stall and each beat
//   yields at most one result; a beat with a payload byte and a status queues both.
// Results wait in a four-entry queue; input stalls when fewer than two slots are free.
// Reset (rst_n low, synchronous): parser back to header byte zero, all header
//   state cleared, result queue emptied.
// ----------------------------------------------------------------------------
// websocket_frame_parser_core
// Byte-per-beat receive-side frame header parser with payload unmasking.
// ----------------------------------------------------------------------------
module websocket_frame_parser_core
  import wsfp_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  ws_in_t  in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output ws_out_t out_data
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             hcnt_r, hcnt_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   mask_r, mask_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [LENGTH_BITS-1:0] pcnt_r, pcnt_nxt;

  ws_out_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   qcnt_r;

  logic       accept, pop;
  logic       pay_hit, complete, trunc, go_after_len, go_body;
  logic [7:0] key_byte;
  logic [6:0] len7;
  logic [1:0] n_res;
  ws_out_t    res0, res1, stat_item;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = qcnt_r > QCNT_W'(QDEPTH - 2);
  assign out_valid = qcnt_r != '0;
  assign out_data  = q_mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    phase_nxt    = phase_r;
    hcnt_nxt     = hcnt_r;
    opcode_nxt   = opcode_r;
    mask_nxt     = mask_r;
    len_nxt      = len_r;
    key_nxt      = key_r;
    pcnt_nxt     = pcnt_r;
    pay_hit      = 1'b0;
    complete     = 1'b0;
    go_after_len = 1'b0;
    go_body      = 1'b0;
    key_byte     = '0;
    len7         = in_data.data_byte[6:0];

    case (phase_r)
      PH_HDR1: begin
        mask_nxt = in_data.data_byte[7];
        len_nxt  = '0;
        if (len7 == LEN_CODE_16) begin
          hcnt_nxt  = 4'd2;
          phase_nxt = PH_EXT;
        end else if (len7 == LEN_CODE_64) begin
          hcnt_nxt  = 4'd8;
          phase_nxt = PH_EXT;
        end else begin
          len_nxt      = LENGTH_BITS'(len7);
          go_after_len = 1'b1;
        end
      end
      PH_EXT: begin
        // saturate once the top byte is occupied
        if (len_r[LENGTH_BITS-1 -: 8] != '0) begin
          len_nxt = '1;
        end else begin
          len_nxt = {len_r[LENGTH_BITS-9:0], in_data.data_byte};
        end
        hcnt_nxt = hcnt_r - 4'd1;
        if (hcnt_nxt == '0) begin
          go_after_len = 1'b1;
        end
      end
      PH_MASK: begin
        key_nxt  = {key_r[23:0], in_data.data_byte};
        hcnt_nxt = hcnt_r - 4'd1;
        if (hcnt_nxt == '0) begin
          go_body = 1'b1;
        end
      end
      PH_PAY: begin
        pay_hit = 1'b1;
        if (mask_r) begin
          case (pcnt_r[1:0])
            2'd0:    key_byte = key_r[31:24];
            2'd1:    key_byte = key_r[23:16];
            2'd2:    key_byte = key_r[15:8];
            default: key_byte = key_r[7:0];
          endcase
        end
        pcnt_nxt = pcnt_r + 1'b1;
        if (pcnt_nxt == len_r) begin
          phase_nxt = PH_DONE;
          complete  = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
        opcode_nxt = in_data.data_byte[3:0];
        mask_nxt   = 1'b0;
        len_nxt    = '0;
        key_nxt    = '0;
        pcnt_nxt   = '0;
        hcnt_nxt   = '0;
        phase_nxt  = PH_HDR1;
      end
    endcase

    if (go_after_len) begin
      if (mask_nxt) begin
        phase_nxt = PH_MASK;
        hcnt_nxt  = 4'd4;
      end else begin
        go_body = 1'b1;
      end
    end
    if (go_body) begin
      pcnt_nxt = '0;
      if (len_nxt == '0) begin
        phase_nxt = PH_DONE;
        complete  = 1'b1;
      end else begin
        phase_nxt = PH_PAY;
      end
    end

    trunc = in_data.chunk_end && (phase_nxt != PH_DONE);

    // status beat carries header state as it stands after this byte
    stat_item.result_kind  = KIND_STATUS;
    stat_item.payload_byte = '0;
    stat_item.frame_opcode = opcode_nxt;
    stat_item.frame_status = complete ? action_of(opcode_nxt) : ST_TRUNC;
    stat_item.frame_length = 64'(len_nxt);
    stat_item.last_result  = 1'b1;

    if (pay_hit) begin
      res0.result_kind  = KIND_PAYLOAD;
      res0.payload_byte = in_data.data_byte ^ key_byte;
      res0.frame_opcode = opcode_r;
      res0.frame_status = '0;
      res0.frame_length = 64'(len_r);
      res0.last_result  = !(complete || trunc);
      res1              = stat_item;
      n_res             = (complete || trunc) ? 2'd2 : 2'd1;
    end else begin
      res0  = stat_item;
      res1  = stat_item;
      n_res = (complete || trunc) ? 2'd1 : 2'd0;
    end

    if (in_data.chunk_end) begin
      phase_nxt  = PH_HDR0;
      hcnt_nxt   = '0;
      opcode_nxt = '0;
      mask_nxt   = 1'b0;
      len_nxt    = '0;
      key_nxt    = '0;
      pcnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      hcnt_r   <= '0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      key_r    <= '0;
      pcnt_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      pcnt_r   <= pcnt_nxt;
    end
  end

  // result queue: up to two writes and one read per cycle
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      q_mem[wr_ptr_r] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      q_mem[wr_ptr_r + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      qcnt_r   <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      qcnt_r <= qcnt_r + (accept ? QCNT_W'(n_res) : '0) - QCNT_W'(pop);
    end
  end

endmodule

### sv/wsfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_checker
// Port-level checks on the frame parser's result channel.
// ----------------------------------------------------------------------------
module wsfp_checker
  import wsfp_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input ws_in_t  in_data,
  input logic    out_valid,
  input logic    out_stall,
  input ws_out_t out_data
);

  // held beat stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a payload byte that is not last is followed at once by its status
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.result_kind == KIND_PAYLOAD &&
    !out_data.last_result |=> out_valid && out_data.result_kind == KIND_STATUS)
    else $error("payload beat not followed by status");

  a_pay_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_PAYLOAD |-> out_data.frame_status == ST_TEXT)
    else $error("payload beat carries a status code");

  a_stat_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_STATUS |->
      out_data.payload_byte == '0 && out_data.last_result && out_data.frame_status != 3'd7)
    else $error("malformed status beat");

  // a reset cycle leaves no result beat offered
  a_no_spurious: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind websocket_frame_parser_core wsfp_checker u_wsfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
